>>> hdl/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define SPG_ASSERT_SAME(lbl, clk_s, rst_s, pre, post, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define SPG_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hdl/spg_pkg.sv
package spg_pkg;

    // grid limits and sine table size
    localparam int MAX_WIDTH = 128;
    localparam int MAX_HEIGHT = 64;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_BITS = SINE_IDX_BITS - 2;
    localparam int QTR_DEPTH = SINE_TABLE_DEPTH / 4;
    localparam int PHASE_PER_ENTRY = 65536 / SINE_TABLE_DEPTH;

    localparam int X_LIMIT = MAX_WIDTH / 2 - 1;
    localparam int Y_LIMIT = MAX_HEIGHT / 2 - 1;
    localparam logic [5:0] X_LAST = 6'((X_LIMIT > 63) ? 63 : X_LIMIT);
    localparam logic [4:0] Y_LAST = 5'((Y_LIMIT > 31) ? 31 : Y_LIMIT);

    // 0.2 rad and 0.014 rad in phase counts
    localparam logic [15:0] XY_PHASE_STEP = 16'd2086;
    localparam logic [15:0] DIAG_PHASE_STEP = 16'd146;

    localparam logic [8:0] HUE_TURN = 9'd360;
    localparam logic [8:0] HUE_SEXTANT = 9'd60;
    localparam logic [5:0] SEXTANT_W = 6'd60;

    localparam logic signed [17:0] BRIGHT_BIAS = 18'sd49152;
    // 255/98304 = 85/2^15
    localparam logic [6:0] FULL_MUL = 7'd85;
    // 255/(98304*60) = 17/(3*2^17), the divide by 3 done with 683/2^11
    localparam logic [4:0] PART_MUL = 5'd17;
    localparam logic [9:0] DIV3_MUL = 10'd683;

    // number of register stages from input to output
    localparam int PIPE_STAGES = 7;

    localparam longint unsigned Q30_C1 = 64'd1686629713;
    localparam longint unsigned Q30_C3 = 64'd693598668;
    localparam longint unsigned Q30_C5 = 64'd85569306;
    localparam longint unsigned Q30_C7 = 64'd5026995;
    localparam longint unsigned Q30_C9 = 64'd172272;

    typedef enum logic [2:0] {
        REG_TIME_STEP       = 3'd0,
        REG_FAST_TIME_STEP  = 3'd1,
        REG_SLOW_PHASE_STEP = 3'd2,
        REG_HUE_STEP        = 3'd3
    } cfg_reg_e;

    // which channel is full and which one ramps
    typedef enum logic [2:0] {
        SEC_R_G = 3'd0,
        SEC_G_R = 3'd1,
        SEC_G_B = 3'd2,
        SEC_B_G = 3'd3,
        SEC_B_R = 3'd4,
        SEC_R_B = 3'd5
    } hue_sector_e;

    typedef struct packed {
        logic [5:0] pixel_x;
        logic [4:0] pixel_y;
        logic       frame_start;
    } pix_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic [5:0]  px;
        logic [4:0]  py;
        logic [15:0] time_ph;
        logic [15:0] fast_ph;
        logic [15:0] slow_ph;
        logic [8:0]  hue_ofs;
    } front_t;

    typedef struct packed {
        logic [16:0] level;
        hue_sector_e sector;
        logic [5:0]  weight;
    } wave_t;

    typedef logic [14:0] qtab_t [QTR_DEPTH];

    // quarter-wave magnitude in q14, odd degree-9 polynomial in q30
    function automatic logic [14:0] poly_mag(input longint unsigned r);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned acc;
        longint unsigned s;
        longint unsigned mag;
        u = r << 16;
        u2 = (u * u) >> 30;
        acc = Q30_C7 - ((u2 * Q30_C9) >> 30);
        acc = Q30_C5 - ((u2 * acc) >> 30);
        acc = Q30_C3 - ((u2 * acc) >> 30);
        acc = Q30_C1 - ((u2 * acc) >> 30);
        s = (u * acc) >> 30;
        mag = (s + 64'd32768) >> 16;
        if (mag > 64'd16384)
        begin
            mag = 64'd16384;
        end
        return 15'(mag);
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t tab;
        for (int k = 0; k < QTR_DEPTH; k++)
        begin
            tab[k] = poly_mag(64'(k) * 64'(PHASE_PER_ENTRY));
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();
    localparam logic [14:0] QPEAK = poly_mag(64'd16384);

    // full-turn sine from the quarter table
    function automatic logic signed [15:0] sine_lookup(input logic [15:0] phase);
        logic [SINE_IDX_BITS-1:0] idx;
        logic [1:0]               quad;
        logic [QTR_BITS-1:0]      j;
        logic [14:0]              mag;
        idx = phase[15 -: SINE_IDX_BITS];
        quad = idx[SINE_IDX_BITS-1 -: 2];
        j = idx[QTR_BITS-1:0];
        if (!quad[0])
        begin
            mag = QTAB[j];
        end
        else if (j == '0)
        begin
            mag = QPEAK;
        end
        else
        begin
            // mirrored quarter
            mag = QTAB[QTR_BITS'(0) - j];
        end
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

>>> hdl/sine_plasma_pixel_generator.sv
// sine plasma pixel generator, one bgr pixel per half-resolution coordinate
//
// pix channel: pixel_x, pixel_y and frame_start; a beat with frame_start set
// first advances the three phases and the hue offset, then that pixel is
// computed with the new values. rgb channel: blue, green and red bytes,
// one beat per pixel, in order.
// cfg channel: register index and data, always ready; index 0 time step,
// 1 fast time step, 2 slow phase step, 3 hue step, other indexes ignored.
// write registers only while no pixel is in flight.
//
// seven register stages: the front stage, wave stages a, b and c, and color
// stages a, b and c; rgb_valid comes from the last of them.
// one pixel per cycle is sustained while rgb_ready stays high; the figure
// is set by the register after each table read and each small multiply.
// each stage holds its beat while the next one is full, so when the
// receiver stalls the bubbles close up and pix_ready drops only once all
// seven stages hold a pixel. no beat is lost or repeated.
// reset clears phases and hue offset to zero, loads the default steps and
// empties the pipeline; no clearing pass is needed.
module sine_plasma_pixel_generator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic          pix_valid,
    output logic          pix_ready,
    input  spg_pkg::pix_t pix_data,
    output logic          rgb_valid,
    input  logic          rgb_ready,
    output spg_pkg::rgb_t rgb_data
);

    logic            front_valid;
    logic            front_ready;
    spg_pkg::front_t front_data;

    logic            wave_valid;
    logic            wave_ready;
    spg_pkg::wave_t  wave_data;

    spg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix_data    (pix_data),
        .front_valid (front_valid),
        .front_ready (front_ready),
        .front_data  (front_data)
    );

    spg_wave u_wave (
        .clk         (clk),
        .rst_n       (rst_n),
        .front_valid (front_valid),
        .front_ready (front_ready),
        .front_data  (front_data),
        .wave_valid  (wave_valid),
        .wave_ready  (wave_ready),
        .wave_data   (wave_data)
    );

    spg_color u_color (
        .clk        (clk),
        .rst_n      (rst_n),
        .wave_valid (wave_valid),
        .wave_ready (wave_ready),
        .wave_data  (wave_data),
        .rgb_valid  (rgb_valid),
        .rgb_ready  (rgb_ready),
        .rgb_data   (rgb_data)
    );

endmodule

>>> hdl/spg_front.sv
module spg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              pix_valid,
    output logic              pix_ready,
    input  spg_pkg::pix_t     pix_data,
    output logic              front_valid,
    input  logic              front_ready,
    output spg_pkg::front_t   front_data
);

    logic [15:0] time_step_reg;
    logic [15:0] fast_time_step_reg;
    logic [15:0] slow_phase_step_reg;
    logic [8:0]  hue_step_reg;

    logic [15:0] time_phase_reg;
    logic [15:0] fast_time_phase_reg;
    logic [15:0] slow_phase_reg;
    logic [8:0]  hue_offset_reg;

    logic [15:0] time_phase_next;
    logic [15:0] fast_time_phase_next;
    logic [15:0] slow_phase_next;
    logic [8:0]  hue_offset_next;

    logic            stage_valid_reg;
    spg_pkg::front_t stage_data_reg;
    spg_pkg::front_t stage_data_next;

    logic       accept;
    logic [8:0] hue_step_mod;
    logic [9:0] hue_sum;
    logic [8:0] hue_adv;

    assign cfg_ready = 1'b1;
    assign pix_ready = !stage_valid_reg || front_ready;
    assign accept = pix_valid && pix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= 16'd522;
            fast_time_step_reg <= 16'd678;
            slow_phase_step_reg <= 16'd209;
            hue_step_reg <= 9'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                spg_pkg::REG_TIME_STEP:       time_step_reg <= cfg_data;
                spg_pkg::REG_FAST_TIME_STEP:  fast_time_step_reg <= cfg_data;
                spg_pkg::REG_SLOW_PHASE_STEP: slow_phase_step_reg <= cfg_data;
                spg_pkg::REG_HUE_STEP:        hue_step_reg <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    // hue step reduced mod 360, then added mod 360
    always_comb
    begin
        hue_step_mod = (hue_step_reg >= spg_pkg::HUE_TURN) ?
                       hue_step_reg - spg_pkg::HUE_TURN : hue_step_reg;
        hue_sum = {1'b0, hue_offset_reg} + {1'b0, hue_step_mod};
        hue_adv = (hue_sum >= 10'(spg_pkg::HUE_TURN)) ?
                  9'(hue_sum - 10'(spg_pkg::HUE_TURN)) : 9'(hue_sum);
    end

    always_comb
    begin
        if (pix_data.frame_start)
        begin
            time_phase_next = time_phase_reg + time_step_reg;
            fast_time_phase_next = fast_time_phase_reg + fast_time_step_reg;
            slow_phase_next = slow_phase_reg + slow_phase_step_reg;
            hue_offset_next = hue_adv;
        end
        else
        begin
            time_phase_next = time_phase_reg;
            fast_time_phase_next = fast_time_phase_reg;
            slow_phase_next = slow_phase_reg;
            hue_offset_next = hue_offset_reg;
        end

        stage_data_next.px = (pix_data.pixel_x > spg_pkg::X_LAST) ?
                             spg_pkg::X_LAST : pix_data.pixel_x;
        stage_data_next.py = (pix_data.pixel_y > spg_pkg::Y_LAST) ?
                             spg_pkg::Y_LAST : pix_data.pixel_y;
        stage_data_next.time_ph = time_phase_next;
        stage_data_next.fast_ph = fast_time_phase_next;
        stage_data_next.slow_ph = slow_phase_next;
        stage_data_next.hue_ofs = hue_offset_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_phase_reg <= '0;
            fast_time_phase_reg <= '0;
            slow_phase_reg <= '0;
            hue_offset_reg <= '0;
        end
        else if (accept)
        begin
            time_phase_reg <= time_phase_next;
            fast_time_phase_reg <= fast_time_phase_next;
            slow_phase_reg <= slow_phase_next;
            hue_offset_reg <= hue_offset_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            stage_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_data_reg <= stage_data_next;
        end
    end

    assign front_valid = stage_valid_reg;
    assign front_data = stage_data_reg;

endmodule

>>> hdl/spg_wave.sv
module spg_wave (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            front_valid,
    output logic            front_ready,
    input  spg_pkg::front_t front_data,
    output logic            wave_valid,
    input  logic            wave_ready,
    output spg_pkg::wave_t  wave_data
);

    // stage a: sine arguments and hue
    logic        a_valid_reg;
    logic [15:0] a_arg_x_reg;
    logic [15:0] a_arg_y_reg;
    logic [15:0] a_arg_d_reg;
    logic [8:0]  a_hue_reg;
    logic        a_ready;

    // stage b: sines, sector and ramp weight
    logic                 b_valid_reg;
    logic signed [15:0]   b_sin_x_reg;
    logic signed [15:0]   b_sin_y_reg;
    logic signed [15:0]   b_sin_d_reg;
    spg_pkg::hue_sector_e b_sector_reg;
    logic [5:0]           b_weight_reg;
    logic                 b_ready;

    // stage c: brightness level
    logic           c_valid_reg;
    spg_pkg::wave_t c_data_reg;
    logic           c_ready;

    logic [6:0]  diag_sum;
    logic [15:0] arg_x_next;
    logic [15:0] arg_y_next;
    logic [15:0] arg_d_next;
    logic [9:0]  hue_raw;
    logic [8:0]  hue_next;

    spg_pkg::hue_sector_e sector_next;
    logic [5:0]           rem;
    logic [5:0]           weight_next;

    logic signed [17:0] level_sum;

    assign c_ready = !c_valid_reg || wave_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign front_ready = a_ready;

    always_comb
    begin
        diag_sum = {1'b0, front_data.px} + {2'b00, front_data.py};
        arg_x_next = 16'(front_data.px) * spg_pkg::XY_PHASE_STEP + front_data.time_ph;
        arg_y_next = 16'(front_data.py) * spg_pkg::XY_PHASE_STEP + front_data.fast_ph;
        arg_d_next = 16'(diag_sum) * spg_pkg::DIAG_PHASE_STEP + front_data.slow_ph;
        hue_raw = 10'({diag_sum, 1'b0}) + 10'(front_data.hue_ofs);
        hue_next = (hue_raw >= 10'(spg_pkg::HUE_TURN)) ?
                   9'(hue_raw - 10'(spg_pkg::HUE_TURN)) : 9'(hue_raw);
    end

    // hue split into 60 degree sectors
    always_comb
    begin
        if (a_hue_reg < spg_pkg::HUE_SEXTANT)
        begin
            sector_next = spg_pkg::SEC_R_G;
            rem = 6'(a_hue_reg);
        end
        else if (a_hue_reg < 9'(2 * spg_pkg::HUE_SEXTANT))
        begin
            sector_next = spg_pkg::SEC_G_R;
            rem = 6'(a_hue_reg - spg_pkg::HUE_SEXTANT);
        end
        else if (a_hue_reg < 9'(3 * spg_pkg::HUE_SEXTANT))
        begin
            sector_next = spg_pkg::SEC_G_B;
            rem = 6'(a_hue_reg - 9'(2 * spg_pkg::HUE_SEXTANT));
        end
        else if (a_hue_reg < 9'(4 * spg_pkg::HUE_SEXTANT))
        begin
            sector_next = spg_pkg::SEC_B_G;
            rem = 6'(a_hue_reg - 9'(3 * spg_pkg::HUE_SEXTANT));
        end
        else if (a_hue_reg < 9'(5 * spg_pkg::HUE_SEXTANT))
        begin
            sector_next = spg_pkg::SEC_B_R;
            rem = 6'(a_hue_reg - 9'(4 * spg_pkg::HUE_SEXTANT));
        end
        else
        begin
            sector_next = spg_pkg::SEC_R_B;
            rem = 6'(a_hue_reg - 9'(5 * spg_pkg::HUE_SEXTANT));
        end
        // odd sectors ramp down
        weight_next = sector_next[0] ? spg_pkg::SEXTANT_W - rem : rem;
    end

    always_comb
    begin
        level_sum = 18'(b_sin_x_reg) + 18'(b_sin_y_reg) + 18'(b_sin_d_reg)
                  + spg_pkg::BRIGHT_BIAS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= front_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && front_valid)
        begin
            a_arg_x_reg <= arg_x_next;
            a_arg_y_reg <= arg_y_next;
            a_arg_d_reg <= arg_d_next;
            a_hue_reg <= hue_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_sin_x_reg <= spg_pkg::sine_lookup(a_arg_x_reg);
            b_sin_y_reg <= spg_pkg::sine_lookup(a_arg_y_reg);
            b_sin_d_reg <= spg_pkg::sine_lookup(a_arg_d_reg);
            b_sector_reg <= sector_next;
            b_weight_reg <= weight_next;
        end
        if (c_ready && b_valid_reg)
        begin
            c_data_reg.level <= 17'(level_sum);
            c_data_reg.sector <= b_sector_reg;
            c_data_reg.weight <= b_weight_reg;
        end
    end

    assign wave_valid = c_valid_reg;
    assign wave_data = c_data_reg;

endmodule

>>> hdl/spg_color.sv
module spg_color (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wave_valid,
    output logic           wave_ready,
    input  spg_pkg::wave_t wave_data,
    output logic           rgb_valid,
    input  logic           rgb_ready,
    output spg_pkg::rgb_t  rgb_data
);

    // stage a: level times weight, level times 85
    logic                 a_valid_reg;
    logic [22:0]          a_lw_reg;
    logic [22:0]          a_full_reg;
    spg_pkg::hue_sector_e a_sector_reg;
    logic                 a_ready;

    // stage b: ramp before the divide by 3, full byte
    logic                 b_valid_reg;
    logic [9:0]           b_ramp_reg;
    logic [7:0]           b_full_reg;
    spg_pkg::hue_sector_e b_sector_reg;
    logic                 b_ready;

    // stage c: output register
    logic          c_valid_reg;
    spg_pkg::rgb_t c_data_reg;
    spg_pkg::rgb_t c_data_next;
    logic          c_ready;

    logic [26:0] ramp_prod;
    logic [19:0] div_prod;
    logic [7:0]  part;

    assign c_ready = !c_valid_reg || rgb_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign wave_ready = a_ready;

    assign ramp_prod = 27'(a_lw_reg) * 27'(spg_pkg::PART_MUL);
    assign div_prod = 20'(b_ramp_reg) * 20'(spg_pkg::DIV3_MUL);
    assign part = div_prod[18:11];

    always_comb
    begin
        c_data_next = '0;
        case (b_sector_reg)
            spg_pkg::SEC_R_G:
            begin
                c_data_next.red = b_full_reg;
                c_data_next.green = part;
            end
            spg_pkg::SEC_G_R:
            begin
                c_data_next.red = part;
                c_data_next.green = b_full_reg;
            end
            spg_pkg::SEC_G_B:
            begin
                c_data_next.green = b_full_reg;
                c_data_next.blue = part;
            end
            spg_pkg::SEC_B_G:
            begin
                c_data_next.green = part;
                c_data_next.blue = b_full_reg;
            end
            spg_pkg::SEC_B_R:
            begin
                c_data_next.red = part;
                c_data_next.blue = b_full_reg;
            end
            default:
            begin
                // last sector, red full and blue ramping
                c_data_next.red = b_full_reg;
                c_data_next.blue = part;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= wave_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && wave_valid)
        begin
            a_lw_reg <= 23'(wave_data.level) * 23'(wave_data.weight);
            a_full_reg <= 23'(wave_data.level) * 23'(spg_pkg::FULL_MUL);
            a_sector_reg <= wave_data.sector;
        end
        if (b_ready && a_valid_reg)
        begin
            b_ramp_reg <= ramp_prod[26:17];
            b_full_reg <= a_full_reg[22:15];
            b_sector_reg <= a_sector_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_data_reg <= c_data_next;
        end
    end

    assign rgb_valid = c_valid_reg;
    assign rgb_data = c_data_reg;

endmodule

>>> hdl/spg_checker.sv
`include "assert_macros.svh"

module spg_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          pix_valid,
    input logic          pix_ready,
    input logic          rgb_valid,
    input logic          rgb_ready,
    input spg_pkg::rgb_t rgb_data
);

    // pixels accepted and not yet delivered
    logic [3:0] occ_reg;
    logic [3:0] occ_next;

    always_comb
    begin
        occ_next = occ_reg;
        if (pix_valid && pix_ready && !(rgb_valid && rgb_ready))
        begin
            occ_next = occ_reg + 4'd1;
        end
        else if (!(pix_valid && pix_ready) && rgb_valid && rgb_ready)
        begin
            occ_next = occ_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    `SPG_ASSERT_SAME(a_no_orphan_beat, clk, rst_n, rgb_valid, occ_reg != 4'd0, "rgb beat without pixel")
    `SPG_ASSERT_SAME(a_depth_bound, clk, rst_n, 1'b1, occ_reg <= 4'(spg_pkg::PIPE_STAGES), "too many pixels in flight")
    `SPG_ASSERT_SAME(a_one_dark, clk, rst_n, rgb_valid, (rgb_data.blue == 8'd0 || rgb_data.green == 8'd0 || rgb_data.red == 8'd0), "no dark channel")
    `SPG_ASSERT_NEXT(a_stall_hold, clk, rst_n, rgb_valid && !rgb_ready, rgb_valid && $stable(rgb_data), "stalled beat changed")

endmodule

bind sine_plasma_pixel_generator spg_checker u_spg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb_data  (rgb_data)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 10;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = spg_pkg::PIPE_STAGES + 8;
    localparam int HOLD_CYCLES = 100;
    localparam int MAX_GAP = 8;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 103;
    localparam int BURST_FIRST = 35;
    localparam int BURST_LAST = 60;
    localparam int FIRST_SPARE_REG = 4;
    localparam int LAST_SPARE_REG = 7;

    // plasma arithmetic
    localparam int SINE_DEPTH = spg_pkg::SINE_TABLE_DEPTH;
    localparam int LAST_COL = spg_pkg::MAX_WIDTH / 2 - 1;
    localparam int LAST_ROW = spg_pkg::MAX_HEIGHT / 2 - 1;
    localparam int XY_PHASE_CNT = 2086;
    localparam int DIAG_PHASE_CNT = 146;
    localparam int LEVEL_MID = 49152;
    localparam longint LEVEL_SPAN = 98304;
    localparam int HUE_DEGREES = 360;
    localparam int SECTOR_DEG = 60;
    localparam longint BYTE_MAX = 255;
    localparam longint unsigned SIN_K1 = 64'd1686629713;
    localparam longint unsigned SIN_K3 = 64'd693598668;
    localparam longint unsigned SIN_K5 = 64'd85569306;
    localparam longint unsigned SIN_K7 = 64'd5026995;
    localparam longint unsigned SIN_K9 = 64'd172272;

    localparam logic CHK_LIT = 1'b1;
    localparam logic CHK_PRED = 1'b0;

    typedef struct packed {
        logic          typed;
        spg_pkg::pix_t pix;
        spg_pkg::rgb_t want;
    } dir_row_t;

    localparam int NUM_DIR = 20;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [15:0]   cfg_data = '0;
    logic          pix_valid = 1'b0;
    logic          pix_ready;
    spg_pkg::pix_t pix_data = '0;
    logic          rgb_valid;
    logic          rgb_ready = 1'b0;
    spg_pkg::rgb_t rgb_data;

    // predictor state and register copies
    logic [15:0] ph_time = '0;
    logic [15:0] ph_fast = '0;
    logic [15:0] ph_slow = '0;
    int          hue_ofs = 0;
    logic [15:0] step_time = 16'd522;
    logic [15:0] step_fast = 16'd678;
    logic [15:0] step_slow = 16'd209;
    logic [8:0]  step_hue = 9'd1;
    int          sine_q14 [SINE_DEPTH];

    spg_pkg::rgb_t expected_rgb [$];
    int   mismatches = 0;
    int   rgb_beats = 0;
    int   idle_cycles = 0;
    int   frame_left = 0;
    int   hold_at [2] = '{250, 620};
    int   holds_done = 0;

    // x, y, frame_start; literal expectation only right after reset
    dir_row_t dir_rows [NUM_DIR] = '{
        {CHK_LIT,  6'd0,  5'd0,  1'b0, 8'd0, 8'd0, 8'd127},
        {CHK_PRED, 6'd63, 5'd31, 1'b0, 24'd0},
        {CHK_PRED, 6'd63, 5'd0,  1'b0, 24'd0},
        {CHK_PRED, 6'd0,  5'd31, 1'b0, 24'd0},
        {CHK_PRED, 6'd42, 5'd21, 1'b0, 24'd0},
        {CHK_PRED, 6'd21, 5'd10, 1'b0, 24'd0},
        {CHK_PRED, 6'd1,  5'd1,  1'b0, 24'd0},
        {CHK_PRED, 6'd15, 5'd0,  1'b0, 24'd0},
        {CHK_PRED, 6'd30, 5'd0,  1'b0, 24'd0},
        {CHK_PRED, 6'd45, 5'd0,  1'b0, 24'd0},
        {CHK_PRED, 6'd60, 5'd0,  1'b0, 24'd0},
        {CHK_PRED, 6'd63, 5'd27, 1'b0, 24'd0},
        {CHK_PRED, 6'd63, 5'd31, 1'b1, 24'd0},
        {CHK_PRED, 6'd0,  5'd0,  1'b1, 24'd0},
        {CHK_PRED, 6'd0,  5'd0,  1'b1, 24'd0},
        {CHK_PRED, 6'd32, 5'd16, 1'b1, 24'd0},
        {CHK_PRED, 6'd10, 5'd20, 1'b0, 24'd0},
        {CHK_PRED, 6'd63, 5'd31, 1'b0, 24'd0},
        {CHK_PRED, 6'd5,  5'd25, 1'b1, 24'd0},
        {CHK_PRED, 6'd0,  5'd0,  1'b0, 24'd0}
    };

    sine_plasma_pixel_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb_data  (rgb_data)
    );

    always #CLK_HALF clk = ~clk;

    // sine of a 16-bit phase in q14, odd polynomial on the folded quarter wave
    function automatic int turn_sine(input logic [15:0] ph);
        longint unsigned r;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned acc;
        longint unsigned mag;
        r = ph[13:0];
        if (ph[14])
        begin
            r = 64'd16384 - r;
        end
        u = r << 16;
        u2 = (u * u) >> 30;
        acc = SIN_K7 - ((u2 * SIN_K9) >> 30);
        acc = SIN_K5 - ((u2 * acc) >> 30);
        acc = SIN_K3 - ((u2 * acc) >> 30);
        acc = SIN_K1 - ((u2 * acc) >> 30);
        mag = (((u * acc) >> 30) + 64'd32768) >> 16;
        if (mag > 64'd16384)
        begin
            mag = 64'd16384;
        end
        return ph[15] ? -int'(mag) : int'(mag);
    endfunction

    function automatic int wave(input logic [15:0] ph);
        return sine_q14[(int'(ph) * SINE_DEPTH) >> 16];
    endfunction

    // advances the phases on a frame start, then returns the pixel color
    function automatic spg_pkg::rgb_t plasma_pixel(input spg_pkg::pix_t p);
        int unsigned          x;
        int unsigned          y;
        int                   sum;
        int                   level;
        int                   hue;
        int                   w;
        int                   full;
        int                   part;
        spg_pkg::hue_sector_e sec;
        spg_pkg::rgb_t        px;
        x = p.pixel_x;
        y = p.pixel_y;
        if (p.frame_start)
        begin
            ph_time = ph_time + step_time;
            ph_fast = ph_fast + step_fast;
            ph_slow = ph_slow + step_slow;
            hue_ofs = (hue_ofs + int'(step_hue) % HUE_DEGREES) % HUE_DEGREES;
        end
        if (x > LAST_COL)
        begin
            x = LAST_COL;
        end
        if (y > LAST_ROW)
        begin
            y = LAST_ROW;
        end
        sum = wave(16'(x * XY_PHASE_CNT + ph_time))
            + wave(16'(y * XY_PHASE_CNT + ph_fast))
            + wave(16'((x + y) * DIAG_PHASE_CNT + ph_slow));
        level = sum + LEVEL_MID;
        hue = (2 * int'(x + y) + hue_ofs) % HUE_DEGREES;
        sec = spg_pkg::hue_sector_e'(hue / SECTOR_DEG);
        w = hue % SECTOR_DEG;
        if ((hue / SECTOR_DEG) % 2 == 1)
        begin
            w = SECTOR_DEG - w;
        end
        full = int'((longint'(level) * BYTE_MAX) / LEVEL_SPAN);
        part = int'((longint'(level) * w * BYTE_MAX) / (LEVEL_SPAN * SECTOR_DEG));
        px = '0;
        case (sec)
            spg_pkg::SEC_R_G: begin px.red = 8'(full); px.green = 8'(part); end
            spg_pkg::SEC_G_R: begin px.red = 8'(part); px.green = 8'(full); end
            spg_pkg::SEC_G_B: begin px.green = 8'(full); px.blue = 8'(part); end
            spg_pkg::SEC_B_G: begin px.green = 8'(part); px.blue = 8'(full); end
            spg_pkg::SEC_B_R: begin px.red = 8'(part); px.blue = 8'(full); end
            default: begin px.red = 8'(full); px.blue = 8'(part); end
        endcase
        return px;
    endfunction

    // mostly short frames led by a frame start, with stray frame starts mixed in
    function automatic spg_pkg::pix_t random_pixel();
        spg_pkg::pix_t p;
        p.pixel_x = 6'($urandom_range(0, 63));
        p.pixel_y = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 7))
            0: begin p.pixel_x = '0; p.pixel_y = '0; end
            1: begin p.pixel_x = '1; p.pixel_y = '1; end
            default: ;
        endcase
        if (frame_left == 0)
        begin
            p.frame_start = 1'b1;
            frame_left = $urandom_range(1, 24);
        end
        else
        begin
            p.frame_start = ($urandom_range(0, 15) == 0);
            frame_left--;
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    task automatic send_pix(input spg_pkg::pix_t p, input logic typed,
                            input spg_pkg::rgb_t lit, input int gap);
        spg_pkg::rgb_t want;
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data <= p;
        do @(posedge clk); while (!pix_ready);
        want = plasma_pixel(p);
        if (typed)
        begin
            want = lit;
        end
        expected_rgb.push_back(want);
    endtask

    task automatic wait_idle();
        while (expected_rgb.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no second assignment
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            spg_pkg::REG_TIME_STEP:       step_time = val;
            spg_pkg::REG_FAST_TIME_STEP:  step_fast = val;
            spg_pkg::REG_SLOW_PHASE_STEP: step_slow = val;
            spg_pkg::REG_HUE_STEP:        step_hue = val[8:0];
            default: ;
        endcase
    endtask

    // result checking
    always @(posedge clk)
    begin : rgb_check
        spg_pkg::rgb_t want;
        if (rst_n && rgb_valid && rgb_ready)
        begin
            if (expected_rgb.size() == 0)
            begin
                report_mismatch("rgb beat with nothing expected", int'(rgb_data), 0);
            end
            else
            begin
                want = expected_rgb.pop_front();
                if (rgb_data.blue !== want.blue)
                begin
                    report_mismatch("blue", rgb_data.blue, want.blue);
                end
                if (rgb_data.green !== want.green)
                begin
                    report_mismatch("green", rgb_data.green, want.green);
                end
                if (rgb_data.red !== want.red)
                begin
                    report_mismatch("red", rgb_data.red, want.red);
                end
            end
            rgb_beats++;
        end
    end

    // receiver: random stalls per beat, stall-free stretches, two long hold-offs
    initial
    begin : rgb_sink
        int stall;
        forever
        begin
            if (holds_done < 2 && rgb_beats >= hold_at[holds_done])
            begin
                holds_done++;
                rgb_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = ((rgb_beats / 64) % 4 == 1) ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rgb_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rgb_ready <= 1'b1;
            do @(posedge clk); while (!(rgb_valid && rgb_ready));
        end
    end

    always @(posedge clk)
    begin
        if ((pix_valid && pix_ready) || (rgb_valid && rgb_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL sine_plasma_pixel_generator");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [15:0] plan [4];
        int          gap;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            sine_q14[i] = turn_sine(16'((longint'(i) * 65536) / SINE_DEPTH));
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR; i++)
        begin
            send_pix(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want,
                     $urandom_range(0, MAX_GAP));
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                pix_valid <= 1'b0;
                wait_idle();
                for (int k = 0; k < 4; k++)
                begin
                    plan[k] = 16'($urandom_range(0, 65535));
                end
                case (ph)
                    1: plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                    2: plan = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
                    3: plan = '{16'h0001, 16'h8000, 16'h7FFF, 16'd359};
                    4: plan[3] = 16'd360;
                    default: ;
                endcase
                for (int k = int'(spg_pkg::REG_TIME_STEP); k <= int'(spg_pkg::REG_HUE_STEP);
                     k++)
                begin
                    write_reg(3'(k), plan[k]);
                end
                // spare indexes must leave every step alone
                if (ph >= 5)
                begin
                    for (int k = FIRST_SPARE_REG; k <= LAST_SPARE_REG; k++)
                    begin
                        write_reg(3'(k), 16'($urandom_range(0, 65535)));
                    end
                end
                cfg_valid <= 1'b0;
                @(posedge clk);
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                gap = (i >= BURST_FIRST && i < BURST_LAST) ? 0 : $urandom_range(0, MAX_GAP);
                send_pix(random_pixel(), CHK_PRED, '0, gap);
            end
        end

        pix_valid <= 1'b0;
        wait_idle();
        if (mismatches == 0)
        begin
            $display("PASS sine_plasma_pixel_generator");
        end
        else
        begin
            $display("FAIL sine_plasma_pixel_generator");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/spg_pkg.sv
hdl/spg_front.sv
hdl/spg_wave.sv
hdl/spg_color.sv
hdl/sine_plasma_pixel_generator.sv
hdl/spg_checker.sv
tb/sv/tb_top.sv
